// File: hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file of the block imports this package.
package spq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int RANK_BITS_DEF = 8;
    localparam int VALUE_BITS    = 32;

    typedef enum logic [1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_LIST = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // What every cell of the chain does on a clock edge.
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

endpackage

// File: hdl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: the cell chain and its sequencer.
// Depends on spq_pkg and spq_cell.
//
//  channel | ports                                     | role
//  --------+-------------------------------------------+-------------------
//  s_      | s_valid s_ready s_cmd s_item_value         | command word in
//          | s_item_rank                               |
//  m_      | m_valid m_ready m_out_value m_out_rank     | result word out
//          | m_status m_occupancy m_last               |
//
// Enqueue and dequeue act on all cells together: every cell compares and shifts at once.
// A listing holds the input until every stored entry has been emitted, the chain
// rotating by one cell per emitted word; the chain is back in order when it ends.
// Reset clears the fill count, the sequencer and the output valid.
// A stalled result holds the output register, blocks the input and freezes the listing.
module sorted_priority_queue_top #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int RANK_BITS = spq_pkg::RANK_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_cmd,
    input  logic signed [spq_pkg::VALUE_BITS-1:0]  s_item_value,
    input  logic [RANK_BITS-1:0]                  s_item_rank,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [spq_pkg::VALUE_BITS-1:0]  m_out_value,
    output logic [RANK_BITS-1:0]                  m_out_rank,
    output logic [1:0]                            m_status,
    output logic [$clog2(DEPTH+1)-1:0]            m_occupancy,
    output logic                                  m_last
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t                       state_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             idx_reg;
    logic                         m_valid_reg;
    logic signed [VALUE_BITS-1:0] out_value_reg;
    logic [RANK_BITS-1:0]         out_rank_reg;
    status_t                      status_reg;
    logic [CNT_W-1:0]             occupancy_reg;
    logic                         last_reg;

    logic signed [VALUE_BITS-1:0] cell_value [DEPTH];
    logic [RANK_BITS-1:0]         cell_rank  [DEPTH];
    logic                         cell_less  [DEPTH];

    cell_ctrl_t ctrl;
    logic       out_free;
    logic       accept;
    logic       is_full;
    logic       is_empty;
    logic       emit;
    cmd_t       cmd;

    assign cmd      = cmd_t'(s_cmd);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);

    always_comb begin
        ctrl.op = OP_HOLD;
        if (accept) begin
            case (cmd)
                CMD_ENQ:  ctrl.op = is_full ? OP_HOLD : OP_INSERT;
                CMD_DEQ:  ctrl.op = is_empty ? OP_HOLD : OP_SHIFT;
                default:  ctrl.op = OP_HOLD;
            endcase
        end else if (state_reg == S_LIST && out_free) begin
            ctrl.op = OP_ROTATE;
        end
    end

    // A result word is loaded into the output register in this cycle.
    always_comb begin
        emit = 1'b0;
        if (accept) begin
            case (cmd)
                CMD_ENQ:  emit = 1'b1;
                CMD_DEQ:  emit = 1'b1;
                CMD_LIST: emit = is_empty;
                default:  emit = 1'b0;
            endcase
        end else if (state_reg == S_LIST && out_free) begin
            emit = 1'b1;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                         l_less;
        logic signed [VALUE_BITS-1:0] l_value;
        logic [RANK_BITS-1:0]         l_rank;
        logic signed [VALUE_BITS-1:0] r_value;
        logic [RANK_BITS-1:0]         r_rank;

        if (i == 0) begin : g_front
            // The front cell has no left neighbor; it takes the new word
            // whenever it does not keep its own.
            assign l_less  = 1'b1;
            assign l_value = s_item_value;
            assign l_rank  = s_item_rank;
        end else begin : g_mid
            assign l_less  = cell_less[i-1];
            assign l_value = cell_value[i-1];
            assign l_rank  = cell_rank[i-1];
        end

        if (i == DEPTH - 1) begin : g_rear
            assign r_value = cell_value[i];
            assign r_rank  = cell_rank[i];
        end else begin : g_inner
            assign r_value = cell_value[i+1];
            assign r_rank  = cell_rank[i+1];
        end

        spq_cell #(
            .DEPTH     (DEPTH),
            .RANK_BITS (RANK_BITS),
            .IDX       (i)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .new_value   (s_item_value),
            .new_rank    (s_item_rank),
            .left_less   (l_less),
            .left_value  (l_value),
            .left_rank   (l_rank),
            .right_value (r_value),
            .right_rank  (r_rank),
            .wrap_value  (cell_value[0]),
            .wrap_rank   (cell_rank[0]),
            .less        (cell_less[i]),
            .value       (cell_value[i]),
            .rank        (cell_rank[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        case (cmd)
                            CMD_ENQ: begin
                                out_value_reg <= '0;
                                out_rank_reg  <= '0;
                                last_reg      <= 1'b1;
                                if (is_full) begin
                                    status_reg    <= STAT_FULL;
                                    occupancy_reg <= count_reg;
                                end else begin
                                    status_reg    <= STAT_OK;
                                    count_reg     <= count_reg + ONE_CNT;
                                    occupancy_reg <= count_reg + ONE_CNT;
                                end
                            end
                            CMD_DEQ: begin
                                last_reg    <= 1'b1;
                                if (is_empty) begin
                                    status_reg    <= STAT_EMPTY;
                                    out_value_reg <= '0;
                                    out_rank_reg  <= '0;
                                    occupancy_reg <= count_reg;
                                end else begin
                                    status_reg    <= STAT_OK;
                                    out_value_reg <= cell_value[0];
                                    out_rank_reg  <= cell_rank[0];
                                    count_reg     <= count_reg - ONE_CNT;
                                    occupancy_reg <= count_reg - ONE_CNT;
                                end
                            end
                            CMD_LIST: begin
                                if (is_empty) begin
                                    status_reg    <= STAT_EMPTY;
                                    out_value_reg <= '0;
                                    out_rank_reg  <= '0;
                                    occupancy_reg <= count_reg;
                                    last_reg      <= 1'b1;
                                end else begin
                                    idx_reg   <= '0;
                                    state_reg <= S_LIST;
                                end
                            end
                            default: begin
                                // The unused code is taken and dropped.
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_LIST: begin
                    if (out_free) begin
                        status_reg    <= STAT_OK;
                        out_value_reg <= cell_value[0];
                        out_rank_reg  <= cell_rank[0];
                        occupancy_reg <= count_reg;
                        last_reg      <= (idx_reg == count_reg - ONE_CNT);
                        idx_reg       <= idx_reg + ONE_CNT;
                        if (idx_reg == count_reg - ONE_CNT) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_value = out_value_reg;
    assign m_out_rank  = out_rank_reg;
    assign m_status    = status_reg;
    assign m_occupancy = occupancy_reg;
    assign m_last      = last_reg;

endmodule

// File: hdl/spq_cell.sv
// One slot of the sorted chain: holds a word and its rank and trades
// contents with its neighbors. Depends on spq_pkg.
module spq_cell #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int RANK_BITS = spq_pkg::RANK_BITS_DEF,
    parameter int IDX       = 0
) (
    input  logic                                 aclk,
    input  spq_pkg::cell_ctrl_t                  ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]           count,
    input  logic signed [spq_pkg::VALUE_BITS-1:0] new_value,
    input  logic [RANK_BITS-1:0]                 new_rank,
    input  logic                                 left_less,
    input  logic signed [spq_pkg::VALUE_BITS-1:0] left_value,
    input  logic [RANK_BITS-1:0]                 left_rank,
    input  logic signed [spq_pkg::VALUE_BITS-1:0] right_value,
    input  logic [RANK_BITS-1:0]                 right_rank,
    input  logic signed [spq_pkg::VALUE_BITS-1:0] wrap_value,
    input  logic [RANK_BITS-1:0]                 wrap_rank,
    output logic                                 less,
    output logic signed [spq_pkg::VALUE_BITS-1:0] value,
    output logic [RANK_BITS-1:0]                 rank
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

    logic signed [VALUE_BITS-1:0] value_reg, value_next;
    logic [RANK_BITS-1:0]         rank_reg, rank_next;
    logic                         occupied;
    logic                         is_tail;

    assign occupied = (MY_IDX < count);
    assign is_tail  = (count == MY_NEXT);
    // Sorted order makes these bits a prefix along the chain.
    assign less     = occupied && (rank_reg < new_rank);

    always_comb begin
        value_next = value_reg;
        rank_next  = rank_reg;
        case (ctrl.op)
            OP_INSERT: begin
                if (!less) begin
                    if (left_less) begin
                        value_next = new_value;
                        rank_next  = new_rank;
                    end else begin
                        value_next = left_value;
                        rank_next  = left_rank;
                    end
                end
            end
            OP_SHIFT: begin
                value_next = right_value;
                rank_next  = right_rank;
            end
            OP_ROTATE: begin
                // The rear entry takes the front one, so the occupied part
                // of the chain turns as a ring.
                if (is_tail) begin
                    value_next = wrap_value;
                    rank_next  = wrap_rank;
                end else begin
                    value_next = right_value;
                    rank_next  = right_rank;
                end
            end
            default: begin
                value_next = value_reg;
                rank_next  = rank_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        rank_reg  <= rank_next;
    end

    assign value = value_reg;
    assign rank  = rank_reg;

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_priority_queue_top: a shadow sorted list predicts
// every result word, and the result checker compares each one field by field.
// Depends on spq_pkg and the RTL of the block; reads no files.
module tb;
    import spq_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int RANK_BITS    = RANK_BITS_DEF;
    localparam int OCC_BITS     = $clog2(DEPTH + 1);
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 4 * DEPTH + 16;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    typedef struct {
        logic signed [VALUE_BITS-1:0] value;
        logic [RANK_BITS-1:0]         rank;
        logic [1:0]                   status;
        logic [OCC_BITS-1:0]          occupancy;
        logic                         last;
    } queue_word_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [1:0]                    s_cmd;
    logic signed [VALUE_BITS-1:0]  s_item_value;
    logic [RANK_BITS-1:0]          s_item_rank;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [VALUE_BITS-1:0]  m_out_value;
    logic [RANK_BITS-1:0]          m_out_rank;
    logic [1:0]                    m_status;
    logic [OCC_BITS-1:0]           m_occupancy;
    logic                          m_last;

    // Shadow copy of the sorted store, front at index 0.
    logic signed [VALUE_BITS-1:0]  shadow_value [DEPTH];
    logic [RANK_BITS-1:0]          shadow_rank  [DEPTH];
    int                            shadow_fill;
    queue_word_t                   expected_words [$];

    bit sender_idle   = 1'b1;
    bit receiver_idle = 1'b1;
    int receiver_hold = 0;

    int mismatch_count = 0;
    int words_checked  = 0;
    int cycle_count    = 0;
    int peak_fill      = 0;
    int n_enqueue      = 0;
    int n_dequeue      = 0;
    int n_list         = 0;
    int n_reserved     = 0;
    int n_dropped      = 0;
    int n_empty        = 0;

    sorted_priority_queue_top #(
        .DEPTH     (DEPTH),
        .RANK_BITS (RANK_BITS)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_item_value (s_item_value),
        .s_item_rank  (s_item_rank),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_value  (m_out_value),
        .m_out_rank   (m_out_rank),
        .m_status     (m_status),
        .m_occupancy  (m_occupancy),
        .m_last       (m_last)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one accepted command to the shadow store and queues the words it yields.
    task automatic predict_queue_words(input logic [1:0] cmd,
                                       input logic signed [VALUE_BITS-1:0] value,
                                       input logic [RANK_BITS-1:0] rank);
        int pos;
        int i;
        queue_word_t w;
        w.value     = '0;
        w.rank      = '0;
        w.status    = STAT_OK;
        w.occupancy = '0;
        w.last      = 1'b1;
        if (cmd == CMD_ENQ) begin
            n_enqueue++;
            if (shadow_fill >= DEPTH) begin
                w.status = STAT_FULL;
                n_dropped++;
            end else begin
                // Insert ahead of the first entry whose rank is not smaller.
                pos = 0;
                while (pos < shadow_fill && shadow_rank[pos] < rank) pos++;
                for (i = shadow_fill; i > pos; i--) begin
                    shadow_value[i] = shadow_value[i-1];
                    shadow_rank[i]  = shadow_rank[i-1];
                end
                shadow_value[pos] = value;
                shadow_rank[pos]  = rank;
                shadow_fill++;
                if (shadow_fill > peak_fill) peak_fill = shadow_fill;
            end
            w.occupancy = OCC_BITS'(shadow_fill);
            expected_words.push_back(w);
        end else if (cmd == CMD_DEQ) begin
            n_dequeue++;
            if (shadow_fill == 0) begin
                w.status = STAT_EMPTY;
                n_empty++;
            end else begin
                w.value = shadow_value[0];
                w.rank  = shadow_rank[0];
                for (i = 1; i < shadow_fill; i++) begin
                    shadow_value[i-1] = shadow_value[i];
                    shadow_rank[i-1]  = shadow_rank[i];
                end
                shadow_fill--;
            end
            w.occupancy = OCC_BITS'(shadow_fill);
            expected_words.push_back(w);
        end else if (cmd == CMD_LIST) begin
            n_list++;
            w.occupancy = OCC_BITS'(shadow_fill);
            if (shadow_fill == 0) begin
                w.status = STAT_EMPTY;
                n_empty++;
                expected_words.push_back(w);
            end else begin
                for (i = 0; i < shadow_fill; i++) begin
                    w.value = shadow_value[i];
                    w.rank  = shadow_rank[i];
                    w.last  = (i == shadow_fill - 1);
                    expected_words.push_back(w);
                end
            end
        end else begin
            // The unused command code is swallowed without a word.
            n_reserved++;
        end
    endtask

    function automatic void check_word(input queue_word_t got);
        queue_word_t want;
        if (expected_words.size() == 0) begin
            $error("unexpected result word: out_value %0d out_rank %0d status %0d",
                   got.value, got.rank, got.status);
            mismatch_count++;
            return;
        end
        want = expected_words.pop_front();
        words_checked++;
        if (got.value !== want.value) begin
            $error("out_value mismatch: expected %0d, got %0d", want.value, got.value);
            mismatch_count++;
        end
        if (got.rank !== want.rank) begin
            $error("out_rank mismatch: expected %0d, got %0d", want.rank, got.rank);
            mismatch_count++;
        end
        if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
        end
        if (got.occupancy !== want.occupancy) begin
            $error("occupancy mismatch: expected %0d, got %0d",
                   want.occupancy, got.occupancy);
            mismatch_count++;
        end
        if (got.last !== want.last) begin
            $error("last mismatch: expected %0d, got %0d", want.last, got.last);
            mismatch_count++;
        end
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Narrow ranks are favored so that ties are common.
    function automatic logic [RANK_BITS-1:0] pick_rank();
        case ($urandom_range(0, 5))
            0, 1:    return RANK_BITS'($urandom_range(0, 3));
            2:       return '1;
            3:       return '0;
            default: return RANK_BITS'($urandom);
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the word is accepted.
    task automatic send_word(input logic [1:0] cmd,
                             input logic signed [VALUE_BITS-1:0] value,
                             input logic [RANK_BITS-1:0] rank);
        int gap;
        gap = sender_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_item_value <= value;
        s_item_rank  <= rank;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        predict_queue_words(cmd, value, rank);
    endtask

    task automatic wait_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_words.size() != 0);
    endtask

    task automatic test_empty_queue();
        send_word(CMD_DEQ, pick_value(), pick_rank());
        send_word(CMD_LIST, pick_value(), pick_rank());
        send_word(CMD_RESERVED, pick_value(), pick_rank());
    endtask

    // Fills the store with extreme values and tied ranks, overflows it, lists it,
    // then takes a few entries off the front.
    task automatic test_fill_and_overflow();
        int i;
        logic signed [VALUE_BITS-1:0] value;
        logic [RANK_BITS-1:0] rank;
        for (i = 0; i < DEPTH; i++) begin
            case (i)
                0:       value = 32'h7fffffff;
                1:       value = 32'h80000000;
                2:       value = '0;
                3:       value = '1;
                default: value = $urandom;
            endcase
            case (i % 4)
                0:       rank = '1;
                1:       rank = '0;
                2:       rank = RANK_BITS'(128);
                default: rank = RANK_BITS'(i);
            endcase
            send_word(CMD_ENQ, value, rank);
        end
        send_word(CMD_ENQ, 32'h12345678, '0);
        send_word(CMD_LIST, pick_value(), pick_rank());
        repeat (3) send_word(CMD_DEQ, pick_value(), pick_rank());
        wait_until_drained();
    endtask

    // The result side stops for a long stretch while commands keep coming.
    task automatic test_output_backpressure();
        int k;
        int pick;
        sender_idle   = 1'b0;
        receiver_hold = HOLD_CYCLES;
        for (k = 0; k < 40; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)      send_word(CMD_ENQ, pick_value(), pick_rank());
            else if (pick < 8) send_word(CMD_LIST, pick_value(), pick_rank());
            else               send_word(CMD_DEQ, pick_value(), pick_rank());
        end
        wait_until_drained();
        sender_idle = 1'b1;
    endtask

    // Phases alternate between filling, draining and a balanced mix, with idling
    // switched on and off on either side.
    task automatic test_random_traffic();
        int phase;
        int k;
        int pick;
        int enq_share;
        for (phase = 0; phase < 8; phase++) begin
            sender_idle   = (phase % 3) != 2;
            receiver_idle = (phase % 4) != 3;
            case (phase % 3)
                0:       enq_share = 62;
                1:       enq_share = 26;
                default: enq_share = 44;
            endcase
            for (k = 0; k < 48; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    send_word(CMD_RESERVED, pick_value(), pick_rank());
                else if (pick < 13)
                    send_word(CMD_LIST, pick_value(), pick_rank());
                else if (pick < 13 + enq_share)
                    send_word(CMD_ENQ, pick_value(), pick_rank());
                else
                    send_word(CMD_DEQ, pick_value(), pick_rank());
            end
            wait_until_drained();
        end
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
    endtask

    initial begin : result_checker
        int stall;
        int hold_len;
        queue_word_t got;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (receiver_hold > 0) begin
                hold_len      = receiver_hold;
                receiver_hold = 0;
                m_ready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
            end
            stall = receiver_idle ? $urandom_range(0, 8) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            // Outputs are settled at the falling edge; the word moves at the next rising one.
            do @(negedge aclk); while (!m_valid);
            got.value     = m_out_value;
            got.rank      = m_out_rank;
            got.status    = m_status;
            got.occupancy = m_occupancy;
            got.last      = m_last;
            @(posedge aclk);
            check_word(got);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d words still pending",
                 cycle_count, expected_words.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_cmd        = CMD_ENQ;
        s_item_value = '0;
        s_item_rank  = '0;
        shadow_fill  = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_queue();
        test_fill_and_overflow();
        test_output_backpressure();
        test_random_traffic();

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d enqueues, %0d dequeues, %0d listings and %0d unused codes;",
                 n_enqueue, n_dequeue, n_list, n_reserved);
        $display("checked %0d words, %0d full drops, %0d empty replies, peak fill %0d of %0d.",
                 words_checked, n_dropped, n_empty, peak_fill, DEPTH);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_top.sv
bench/tb.sv
